[hw/rtl/dq_pkg.sv]
// Shared types, codes and defaults for the double-ended queue unit.
package dq_pkg;

    // Default number of queue entries
    localparam int DEPTH_DEF = 64;

    // Width of one stored value
    localparam int DATA_W = 32;

    // Operation selector carried with each request
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_READ = 2'd2
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // capture the accepted request
        logic commit;     // apply the operation to pointers and storage
        logic load_out;   // load the result register
        logic use_rdata;  // result value comes from the storage read
    } dq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_push;    // captured request is a push
        logic ok;         // operation can proceed (not full / not empty)
    } dq_stat_t;

endpackage

[hw/rtl/dq_ram.sv]
// Generic simple dual-port RAM with registered read data.
module dq_ram
    import dq_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dq_ctrl.sv]
// Controller state machine for the double-ended queue unit.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_full_reg;
    logic   out_full_next;
    logic   slot_free;

    // Result register can take a new result this cycle
    assign slot_free = !out_full_reg || m_tready;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.is_push && stat.ok)
                begin
                    state_next = S_READ;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_EXEC:
            begin
                if (!stat.is_push && stat.ok)
                begin
                    // Pop: issue the read and move the pointers now
                    cmd.commit = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.commit   = stat.ok;
                    cmd.load_out = 1'b1;
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.use_rdata = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Result valid: set on load, clear when taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_full_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_full_next = 1'b0;
        end
        else
        begin
            out_full_next = out_full_reg;
        end
    end

    assign m_tvalid = out_full_reg;

    // A read state only follows an execute state or itself
    a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(state_reg) == S_EXEC || $past(state_reg) == S_READ)
        else $error("read state entered without execute");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_full_reg || m_tready)
        else $error("result register overwritten");

    // An accepted request goes to execute next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

endmodule

[hw/rtl/dq_dp.sv]
// Datapath: pointers, entry storage and result register of the queue.
module dq_dp
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int OUT_W = ((DATA_W + 3 + CNT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        s_tuser,
    input  logic [DATA_W-1:0] s_tdata,
    input  dq_cmd_t           cmd,
    output dq_stat_t          stat,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int AW = $clog2(DEPTH);

    mode_t             mode_reg;
    logic [DATA_W-1:0] value_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic [DATA_W-1:0] popped_reg;
    logic [1:0]        status_reg;
    logic              empty_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              is_push;
    logic              is_front;
    logic              full;
    logic              empty;
    logic              ok;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;
    logic [CNT_W-1:0]  offs;
    logic [CNT_W:0]    sum;
    logic [CNT_W:0]    tail;
    logic [AW-1:0]     addr;
    logic [1:0]        status_code;
    logic [DATA_W-1:0] rdata;

    // Capture the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg  <= mode_t'(s_tuser);
            value_reg <= s_tdata;
        end
    end

    // Decode the request against the fill level
    assign is_push  = (mode_reg == MODE_PUSH_FRONT) || (mode_reg == MODE_PUSH_BACK);
    assign is_front = (mode_reg == MODE_PUSH_FRONT) || (mode_reg == MODE_POP_FRONT);
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign ok       = is_push ? !full : !empty;

    assign stat.is_push = is_push;
    assign stat.ok      = ok;

    // Wrap the head one step either way
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Back position: head plus count (push) or count minus one (pop), wrapped
    assign offs = (mode_reg == MODE_PUSH_BACK) ? cnt_reg : cnt_reg - 1'b1;
    assign sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(offs);
    assign tail = (sum >= (CNT_W + 1)'(DEPTH)) ? sum - (CNT_W + 1)'(DEPTH) : sum;

    // Storage address for the current operation
    assign addr = is_front ? (is_push ? head_dec : head_reg) : tail[AW-1:0];

    // Pointer and count updates
    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (cmd.commit)
        begin
            case (mode_reg)
                MODE_PUSH_FRONT:
                begin
                    head_next = head_dec;
                    cnt_next  = cnt_reg + 1'b1;
                end
                MODE_PUSH_BACK:
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                MODE_POP_FRONT:
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
                MODE_POP_BACK:
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.commit && is_push),
        .waddr (addr),
        .wdata (value_reg),
        .re    (cmd.commit && !is_push),
        .raddr (addr),
        .rdata (rdata)
    );

    assign status_code = ok ? ST_DONE : (is_push ? ST_FULL : ST_EMPTY);

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            popped_reg <= cmd.use_rdata ? rdata : '0;
            status_reg <= cmd.use_rdata ? ST_DONE : status_code;
            empty_reg  <= (cnt_next == '0);
            count_reg  <= cnt_next;
        end
    end

    assign m_tdata = OUT_W'({count_reg, empty_reg, status_reg, popped_reg});

    // Count never exceeds capacity
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // Head stays inside the buffer
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer out of range");

    // A committed push grows the count by one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && is_push |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push did not grow the count");

endmodule

[hw/rtl/double_ended_queue_unit.sv]
// Top level of the double-ended queue unit.
// Bounded double-ended queue of DEPTH signed 32-bit entries kept in a circular
// buffer RAM. Each request on the slave stream selects push front, push back,
// pop front or pop back in s_tuser and carries the push value in s_tdata; each
// request gives exactly one result on the master stream with the popped value
// (zero on pushes and failures), a status (done, pop on empty, push on full
// dropped), an empty flag and the entry count after the request. Requests are
// handled one at a time: a push or a failed operation goes from idle through
// execute back to idle, a successful pop also passes through a read state
// because the entry RAM read data is registered. The result register lets the
// next request be accepted while an earlier result waits to be taken.
module double_ended_queue_unit
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int OUT_W = ((DATA_W + 3 + CNT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]        s_tuser,   // [1:0] mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // popped_value, status, is_empty, entry_count, zero pad
);

    dq_cmd_t  cmd;
    dq_stat_t stat;

    // Sequencing
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Pointers, storage and result
    dq_dp #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .OUT_W (OUT_W)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule
